// ===== rtl/shs_pkg.sv =====
// Types and constants for the stepper homing sequencer.
// No dependencies; taken in by the interfaces and the top level.
package shs_pkg;

    localparam int unsigned PosW    = 32;
    localparam int unsigned CourseW = 31;
    localparam int unsigned CfgW    = 31;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [2:0] t_action;
    localparam t_action ACT_NONE   = 3'd0;
    localparam t_action ACT_SHIFT  = 3'd1;
    localparam t_action ACT_RUN    = 3'd2;
    localparam t_action ACT_STOP   = 3'd3;
    localparam t_action ACT_CENTRE = 3'd4;
    localparam t_action ACT_ABORT  = 3'd5;

    typedef logic [2:0] t_outcome;
    localparam t_outcome OUT_BUSY    = 3'd0;
    localparam t_outcome OUT_SUCCESS = 3'd1;
    localparam t_outcome OUT_STALLED = 3'd2;
    localparam t_outcome OUT_SHORT   = 3'd3;
    localparam t_outcome OUT_TIMEOUT = 3'd4;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RUN_CURRENT = 3'd0;
    localparam t_cfg_idx CFG_STALL_THR   = 3'd1;
    localparam t_cfg_idx CFG_TIMEOUT     = 3'd2;
    localparam t_cfg_idx CFG_RELEASE     = 3'd3;
    localparam t_cfg_idx CFG_MIN_RUN     = 3'd4;
    localparam t_cfg_idx CFG_SHIFT       = 3'd5;
    localparam t_cfg_idx CFG_MIN_COURSE  = 3'd6;

    localparam logic OP_START = 1'b0;

    // current tuning limits
    localparam logic [4:0] CUR_RAISE_LIMIT = 5'h1E;
    localparam logic [4:0] CUR_LOWER_LIMIT = 5'h0E;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_RESTART = 8'b0000_0010,
        PH_SHIFT   = 8'b0000_0100,
        PH_FIRST   = 8'b0000_1000,
        PH_WAIT    = 8'b0001_0000,
        PH_RELEASE = 8'b0010_0000,
        PH_OTHER   = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    function automatic logic [2:0] phase_num(input t_phase p);
        logic [2:0] n;
        case (p)
            PH_IDLE:    n = 3'd0;
            PH_RESTART: n = 3'd1;
            PH_SHIFT:   n = 3'd2;
            PH_FIRST:   n = 3'd3;
            PH_WAIT:    n = 3'd4;
            PH_RELEASE: n = 3'd5;
            PH_OTHER:   n = 3'd6;
            PH_DONE:    n = 3'd7;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/shs_if.sv =====
// Request and result channels of the stepper homing sequencer.
// Depends on shs_pkg for field widths.
interface shs_req_if;
    import shs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic                   standstill;
    logic                   stall_flag;
    logic signed [PosW-1:0] position;

    modport source (output valid, opcode, standstill, stall_flag, position, input ready);
    modport sink   (input valid, opcode, standstill, stall_flag, position, output ready);
endinterface

interface shs_rsp_if;
    import shs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [2:0]            action;
    logic                  move_positive;
    logic [4:0]            run_current;
    logic signed [6:0]     stall_threshold;
    logic signed [PosW-1:0] target_position;
    logic [CourseW-1:0]    half_course;
    logic [2:0]            phase;
    logic [2:0]            outcome;

    modport source (output valid, action, move_positive, run_current, stall_threshold,
                    target_position, half_course, phase, outcome, input ready);
    modport sink   (input valid, action, move_positive, run_current, stall_threshold,
                    target_position, half_course, phase, outcome, output ready);
endinterface

// ===== rtl/stepper_homing_sequencer.sv =====
// Stepper homing sequencer: a result is valid the cycle after its request is taken.
// Throughput 1 request per cycle unless results stall; the result register frees as
// it is taken, so a new request enters in the same cycle the previous result leaves.
// Synchronous active-low reset: configuration back to defaults, phase idle,
// tuning, counters and course cleared, no result pending.
// Depends on shs_pkg and the channel interfaces in shs_if.sv.
module stepper_homing_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shs_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [shs_pkg::CfgW-1:0]       i_cfg_data,
    shs_req_if.sink                        i_req,
    shs_rsp_if.source                      o_rsp
);
    import shs_pkg::*;

    // configuration
    logic [4:0]         r_cfg_cur;
    logic [6:0]         r_cfg_thr;
    logic [9:0]         r_cfg_tmo;
    logic [7:0]         r_cfg_rel;
    logic [7:0]         r_cfg_minrun;
    logic [19:0]        r_cfg_shift;
    logic [30:0]        r_cfg_mincourse;

    // sequencer state
    t_phase             r_phase, n_phase;
    logic [4:0]         r_cur, n_cur;
    logic [6:0]         r_thr, n_thr;
    logic [9:0]         r_tmo, n_tmo;
    logic [7:0]         r_run, n_run;
    logic [7:0]         r_rel, n_rel;
    logic               r_dir, n_dir;
    logic [CourseW-1:0] r_course, n_course;
    t_outcome           r_outcome, n_outcome;

    // result register
    logic               r_out_valid;
    t_action            r_act, n_act;
    logic               r_pos, n_pos;
    logic [PosW-1:0]    r_tgt, n_tgt;

    logic               accept;
    logic               expired;
    logic               count;
    t_outcome           fail;
    logic               neg;
    logic [PosW-1:0]    mag;
    logic [CourseW-1:0] half;
    logic [PosW-1:0]    shift_tgt;
    logic [PosW-1:0]    shift_tgt_n;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign expired     = (r_tmo == '0);

    assign neg  = i_req.position[PosW-1];
    assign mag  = neg ? (PosW'(0) - PosW'(i_req.position)) : PosW'(i_req.position);
    assign half = mag[PosW-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cur       <= 5'd18;
            r_cfg_thr       <= 7'd5;
            r_cfg_tmo       <= 10'd100;
            r_cfg_rel       <= 8'd20;
            r_cfg_minrun    <= 8'd3;
            r_cfg_shift     <= 20'd25000;
            r_cfg_mincourse <= 31'd76800;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RUN_CURRENT: r_cfg_cur       <= i_cfg_data[4:0];
                CFG_STALL_THR:   r_cfg_thr       <= i_cfg_data[6:0];
                CFG_TIMEOUT:     r_cfg_tmo       <= i_cfg_data[9:0];
                CFG_RELEASE:     r_cfg_rel       <= i_cfg_data[7:0];
                CFG_MIN_RUN:     r_cfg_minrun    <= i_cfg_data[7:0];
                CFG_SHIFT:       r_cfg_shift     <= i_cfg_data[19:0];
                CFG_MIN_COURSE:  r_cfg_mincourse <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_thr     = r_thr;
        n_tmo     = r_tmo;
        n_run     = r_run;
        n_rel     = r_rel;
        n_dir     = r_dir;
        n_course  = r_course;
        n_outcome = r_outcome;
        n_act     = ACT_NONE;
        n_pos     = 1'b0;
        n_tgt     = '0;
        count     = 1'b0;
        fail      = OUT_BUSY;
        shift_tgt = '0;
        shift_tgt_n = '0;

        if (i_req.opcode == OP_START) begin
            n_cur     = r_cfg_cur;
            n_thr     = r_cfg_thr;
            n_dir     = 1'b1;
            n_tmo     = r_cfg_tmo;
            n_run     = '0;
            n_rel     = '0;
            n_outcome = OUT_BUSY;
            n_course  = '0;
            n_act     = ACT_SHIFT;
            n_pos     = 1'b1;
            n_tgt     = {12'd0, r_cfg_shift};
            n_phase   = PH_SHIFT;
            count     = 1'b1;
        end else begin
            count = 1'b1;
            case (r_phase)
                PH_RESTART: begin
                    shift_tgt_n = PosW'(0) - {12'd0, r_cfg_shift};
                    shift_tgt   = r_dir ? {12'd0, r_cfg_shift} : shift_tgt_n;
                    n_act   = ACT_SHIFT;
                    n_pos   = r_dir;
                    n_tgt   = shift_tgt;
                    n_phase = PH_SHIFT;
                end
                PH_SHIFT: begin
                    if (i_req.standstill) begin
                        n_act   = ACT_RUN;
                        n_pos   = !r_dir;
                        n_phase = PH_FIRST;
                        n_run   = '0;
                    end else if (expired) begin
                        fail = OUT_TIMEOUT;
                    end
                end
                PH_FIRST: begin
                    if (i_req.stall_flag || expired) begin
                        n_act = ACT_STOP;
                        if (expired) begin
                            // no end found: reverse with less current
                            n_tmo   = r_cfg_tmo;
                            n_dir   = !r_dir;
                            n_phase = PH_RESTART;
                            if (r_cur > CUR_LOWER_LIMIT) begin
                                n_cur = r_cur - 5'd2;
                                n_thr = r_thr - 7'd1;
                            end
                        end else if (r_run < r_cfg_minrun) begin
                            // stalled too early: reverse with more current
                            n_dir   = !r_dir;
                            n_phase = PH_RESTART;
                            if (r_cur < CUR_RAISE_LIMIT) begin
                                n_cur = r_cur + 5'd2;
                                n_thr = r_thr + 7'd1;
                            end
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                end
                PH_WAIT: begin
                    if (i_req.standstill) begin
                        n_act   = ACT_RUN;
                        n_pos   = r_dir;
                        n_phase = PH_RELEASE;
                        n_rel   = r_cfg_rel;
                    end else if (expired) begin
                        fail = OUT_TIMEOUT;
                    end
                end
                PH_RELEASE: begin
                    count = 1'b0;
                    if (!i_req.stall_flag) begin
                        n_phase = PH_OTHER;
                    end else if (r_rel <= 8'd1) begin
                        n_rel = '0;
                        fail  = OUT_STALLED;
                    end else begin
                        n_rel = r_rel - 8'd1;
                    end
                end
                PH_OTHER: begin
                    if (i_req.stall_flag || expired) begin
                        if (mag < {1'b0, r_cfg_mincourse}) begin
                            fail = OUT_SHORT;
                        end else begin
                            n_course  = half;
                            n_outcome = OUT_SUCCESS;
                            n_phase   = PH_DONE;
                            n_act     = ACT_CENTRE;
                            n_tgt     = neg ? {1'b0, half} : (PosW'(0) - {1'b0, half});
                            n_pos     = neg && (half != '0);
                        end
                    end
                end
                default: begin
                    count = 1'b0;
                end
            endcase
            if (fail != OUT_BUSY) begin
                n_act     = ACT_ABORT;
                n_pos     = 1'b0;
                n_tgt     = '0;
                n_outcome = fail;
                n_phase   = PH_DONE;
            end
        end

        if (count && n_phase != PH_DONE) begin
            if (n_tmo != '0) begin
                n_tmo = n_tmo - 10'd1;
            end
            if (n_run != 8'hFF) begin
                n_run = n_run + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cur       <= '0;
            r_thr       <= '0;
            r_tmo       <= '0;
            r_run       <= '0;
            r_rel       <= '0;
            r_dir       <= 1'b1;
            r_course    <= '0;
            r_outcome   <= OUT_BUSY;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_cur     <= n_cur;
                r_thr     <= n_thr;
                r_tmo     <= n_tmo;
                r_run     <= n_run;
                r_rel     <= n_rel;
                r_dir     <= n_dir;
                r_course  <= n_course;
                r_outcome <= n_outcome;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= n_act;
            r_pos <= n_pos;
            r_tgt <= n_tgt;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.action          = r_act;
    assign o_rsp.move_positive   = r_pos;
    assign o_rsp.run_current     = r_cur;
    assign o_rsp.stall_threshold = r_thr;
    assign o_rsp.target_position = r_tgt;
    assign o_rsp.half_course     = r_course;
    assign o_rsp.phase           = phase_num(r_phase);
    assign o_rsp.outcome         = r_outcome;

    // a new request never overwrites a result that is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !accept)
        else $error("request accepted over a held result");

    // an abort always ends in done with a failure outcome
    a_abort_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_act == ACT_ABORT) |->
            (r_phase == PH_DONE && r_outcome != OUT_BUSY && r_outcome != OUT_SUCCESS))
        else $error("abort without failure outcome");

    // centre move only on success, with the course recorded
    a_centre_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_act == ACT_CENTRE) |->
            (r_phase == PH_DONE && r_outcome == OUT_SUCCESS))
        else $error("centre move without success");

    // outcome is busy whenever the sequence is still running
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE && r_phase != PH_IDLE) |-> (r_outcome == OUT_BUSY))
        else $error("outcome set while sequence runs");

    // direction flag stays low for actions that carry no move
    a_dir_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_act == ACT_NONE || r_act == ACT_STOP || r_act == ACT_ABORT))
            |-> !r_pos)
        else $error("direction set on a non-move action");

endmodule

// ===== test/stepper_homing_sequencer_chk.sv =====
// Result checker for the stepper homing sequencer: mirrors register writes, predicts
// each result from the accepted requests and compares it field by field.
// Depends on shs_pkg and the channel interfaces in shs_if.sv.
`timescale 1ns / 100ps
module stepper_homing_sequencer_chk
    import shs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    shs_req_if              i_req,
    shs_rsp_if              i_rsp,
    output int              o_fail_count,
    output int              o_pending
);

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_RESTART, SEQ_SHIFT, SEQ_FIRST,
        SEQ_WAIT, SEQ_RELEASE, SEQ_OTHER, SEQ_DONE
    } t_seq_phase;

    typedef struct packed {
        t_action      action;
        logic         move_positive;
        logic [4:0]   run_current;
        logic [6:0]   stall_threshold;
        logic [31:0]  target_position;
        logic [30:0]  half_course;
        logic [2:0]   phase;
        t_outcome     outcome;
    } t_homing_result;

    // register mirror
    logic [4:0]  cfg_run_current;
    logic [6:0]  cfg_stall_thr;
    logic [9:0]  cfg_timeout;
    logic [7:0]  cfg_release;
    logic [7:0]  cfg_min_run;
    logic [19:0] cfg_shift;
    logic [30:0] cfg_min_course;

    // sequencer state
    t_seq_phase  seq_phase;
    logic [4:0]  run_current;
    logic [6:0]  stall_thr;
    logic [9:0]  ticks_left;
    logic [7:0]  run_ticks;
    logic [7:0]  release_left;
    logic        dir_positive;
    logic [31:0] centre;
    logic [30:0] half_course;
    t_outcome    outcome;

    t_homing_result expected_results[$];
    int fail_count = 0;
    int pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [31:0] shift_target();
        return dir_positive ? {12'b0, cfg_shift} : -{12'b0, cfg_shift};
    endfunction

    task automatic predict_homing(input logic op, input logic still, input logic stall,
                                  input logic [31:0] pos, output t_homing_result r);
        logic        counted;
        logic        expired;
        t_outcome    fail;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] half;
        r       = '0;
        counted = 1'b1;
        fail    = OUT_BUSY;
        if (op == OP_START) begin
            run_current     = cfg_run_current;
            stall_thr       = cfg_stall_thr;
            dir_positive    = 1'b1;
            ticks_left      = cfg_timeout;
            run_ticks       = '0;
            release_left    = '0;
            outcome         = OUT_BUSY;
            half_course     = '0;
            centre          = '0;
            r.action        = ACT_SHIFT;
            r.move_positive = 1'b1;
            r.target_position = shift_target();
            seq_phase       = SEQ_SHIFT;
        end else begin
            expired = (ticks_left == 0);
            case (seq_phase)
                SEQ_RESTART: begin
                    r.action          = ACT_SHIFT;
                    r.move_positive   = dir_positive;
                    r.target_position = shift_target();
                    seq_phase         = SEQ_SHIFT;
                end
                SEQ_SHIFT: begin
                    if (still) begin
                        r.action        = ACT_RUN;
                        r.move_positive = !dir_positive;
                        seq_phase       = SEQ_FIRST;
                        run_ticks       = '0;
                    end else if (expired) begin
                        fail = OUT_TIMEOUT;
                    end
                end
                SEQ_FIRST: begin
                    if (stall || expired) begin
                        r.action = ACT_STOP;
                        if (expired) begin
                            // no end found: reverse with less current
                            ticks_left   = cfg_timeout;
                            dir_positive = !dir_positive;
                            if (run_current > CUR_LOWER_LIMIT) begin
                                run_current = run_current - 5'd2;
                                stall_thr   = stall_thr - 7'd1;
                            end
                            seq_phase = SEQ_RESTART;
                        end else if (run_ticks < cfg_min_run) begin
                            // stuck right away: reverse with more current
                            dir_positive = !dir_positive;
                            if (run_current < CUR_RAISE_LIMIT) begin
                                run_current = run_current + 5'd2;
                                stall_thr   = stall_thr + 7'd1;
                            end
                            seq_phase = SEQ_RESTART;
                        end else begin
                            seq_phase = SEQ_WAIT;
                        end
                    end
                end
                SEQ_WAIT: begin
                    if (still) begin
                        r.action        = ACT_RUN;
                        r.move_positive = dir_positive;
                        seq_phase       = SEQ_RELEASE;
                        release_left    = cfg_release;
                    end else if (expired) begin
                        fail = OUT_TIMEOUT;
                    end
                end
                SEQ_RELEASE: begin
                    counted = 1'b0;
                    if (!stall) begin
                        seq_phase = SEQ_OTHER;
                    end else if (release_left <= 8'd1) begin
                        release_left = '0;
                        fail         = OUT_STALLED;
                    end else begin
                        release_left = release_left - 8'd1;
                    end
                end
                SEQ_OTHER: begin
                    if (stall || expired) begin
                        neg = pos[31];
                        mag = neg ? -pos : pos;
                        if (mag < {1'b0, cfg_min_course}) begin
                            fail = OUT_SHORT;
                        end else begin
                            half              = mag >> 1;
                            half_course       = half[30:0];
                            centre            = neg ? half : -half;
                            outcome           = OUT_SUCCESS;
                            seq_phase         = SEQ_DONE;
                            r.action          = ACT_CENTRE;
                            r.target_position = centre;
                            r.move_positive   = neg && (half != 0);
                        end
                    end
                end
                default: counted = 1'b0;
            endcase
            if (fail != OUT_BUSY) begin
                r.action          = ACT_ABORT;
                r.move_positive   = 1'b0;
                r.target_position = '0;
                outcome           = fail;
                seq_phase         = SEQ_DONE;
            end
        end
        if (counted && seq_phase != SEQ_DONE) begin
            if (ticks_left != 0)
                ticks_left = ticks_left - 10'd1;
            if (run_ticks != 8'hFF)
                run_ticks = run_ticks + 8'd1;
        end
        r.run_current     = run_current;
        r.stall_threshold = stall_thr;
        r.half_course     = half_course;
        r.phase           = seq_phase;
        r.outcome         = outcome;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_homing_result want;
        t_homing_result got;
        if (!i_rst_n) begin
            cfg_run_current = 5'd18;
            cfg_stall_thr   = 7'd5;
            cfg_timeout     = 10'd100;
            cfg_release     = 8'd20;
            cfg_min_run     = 8'd3;
            cfg_shift       = 20'd25000;
            cfg_min_course  = 31'd76800;
            seq_phase       = SEQ_IDLE;
            run_current     = '0;
            stall_thr       = '0;
            ticks_left      = '0;
            run_ticks       = '0;
            release_left    = '0;
            dir_positive    = 1'b1;
            centre          = '0;
            half_course     = '0;
            outcome         = OUT_BUSY;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RUN_CURRENT: cfg_run_current = i_cfg_data[4:0];
                    CFG_STALL_THR:   cfg_stall_thr   = i_cfg_data[6:0];
                    CFG_TIMEOUT:     cfg_timeout     = i_cfg_data[9:0];
                    CFG_RELEASE:     cfg_release     = i_cfg_data[7:0];
                    CFG_MIN_RUN:     cfg_min_run     = i_cfg_data[7:0];
                    CFG_SHIFT:       cfg_shift       = i_cfg_data[19:0];
                    CFG_MIN_COURSE:  cfg_min_course  = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // take the result first: it can never belong to a request of this edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request outstanding, action %0d",
                             $time, i_rsp.action);
                    fail_count++;
                end else begin
                    want                = expected_results.pop_front();
                    got.action          = i_rsp.action;
                    got.move_positive   = i_rsp.move_positive;
                    got.run_current     = i_rsp.run_current;
                    got.stall_threshold = i_rsp.stall_threshold;
                    got.target_position = i_rsp.target_position;
                    got.half_course     = i_rsp.half_course;
                    got.phase           = i_rsp.phase;
                    got.outcome         = i_rsp.outcome;
                    check_field("action", 32'(want.action), 32'(got.action));
                    check_field("move_positive", 32'(want.move_positive),
                                32'(got.move_positive));
                    check_field("run_current", 32'(want.run_current), 32'(got.run_current));
                    check_field("stall_threshold", 32'(want.stall_threshold),
                                32'(got.stall_threshold));
                    check_field("target_position", want.target_position, got.target_position);
                    check_field("half_course", 32'(want.half_course), 32'(got.half_course));
                    check_field("phase", 32'(want.phase), 32'(got.phase));
                    check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_homing(i_req.opcode, i_req.standstill, i_req.stall_flag,
                               i_req.position, want);
                expected_results.push_back(want);
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

// ===== test/stepper_homing_sequencer_tb.sv =====
// Testbench top for the stepper homing sequencer: clock, reset, register phases and
// request stimulus; stepper_homing_sequencer_chk predicts and checks the results.
// Depends on shs_pkg, shs_if.sv, the block and the checker.
`timescale 1ns / 100ps
module stepper_homing_sequencer_tb;
    import shs_pkg::*;

    localparam logic OP_POLL       = ~OP_START;
    localparam int   QUIET_LIMIT   = 2000;
    localparam int   RANDOM_PHASES = 8;
    localparam int   PHASE_ITEMS   = 84;
    localparam int   NOISE_PCT     = 12;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    t_cfg_idx        cfg_idx;
    logic [CfgW-1:0] cfg_data;

    int          send_idle_pct = 0;
    int          rsp_stall_pct = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          fail_count;
    int          pending;
    logic [7:0]  shadow_min_run = 8'd3;
    logic [30:0] shadow_min_course = 31'd76800;

    shs_req_if req_ch ();
    shs_rsp_if rsp_ch ();

    stepper_homing_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    stepper_homing_sequencer_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // end the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_req(input logic op, input logic still, input logic stall,
                            input logic [31:0] pos);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.standstill <= still;
        req_ch.stall_flag <= stall;
        req_ch.position   <= pos;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // poll tick that now and then carries random flags instead of the intended ones
    task automatic tick(input logic still, input logic stall, input logic [31:0] pos);
        if ($urandom_range(99) < NOISE_PCT)
            send_req(OP_POLL, coin(), coin(), $urandom());
        else
            send_req(OP_POLL, still, stall, pos);
    endtask

    // hold the request side idle until every result is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [4:0] cur, input logic [6:0] thr,
                               input logic [9:0] tmo, input logic [7:0] rel,
                               input logic [7:0] min_run, input logic [19:0] shift,
                               input logic [30:0] min_course);
        write_reg(CFG_RUN_CURRENT, CfgW'(cur));
        write_reg(CFG_STALL_THR, CfgW'(thr));
        write_reg(CFG_TIMEOUT, CfgW'(tmo));
        write_reg(CFG_RELEASE, CfgW'(rel));
        write_reg(CFG_MIN_RUN, CfgW'(min_run));
        write_reg(CFG_SHIFT, CfgW'(shift));
        write_reg(CFG_MIN_COURSE, min_course);
        cfg_we            <= 1'b0;
        shadow_min_run    = min_run;
        shadow_min_course = min_course;
    endtask

    function automatic logic [30:0] pick_value(input logic [30:0] lo, input logic [30:0] hi,
                                               input logic [30:0] mid);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return mid;
        endcase
    endfunction

    task automatic random_config(input int flavor);
        if (flavor == 0) begin
            load_config(5'd0, 7'h40, 10'd1, 8'd1, 8'd0, 20'd0, 31'd0);
        end else if (flavor == 1) begin
            load_config(5'd31, 7'h3F, 10'd1023, 8'd255, 8'd255, 20'hFFFFF, 31'h7FFFFFFF);
        end else begin
            load_config(5'(pick_value(31'd0, 31'd31, 31'($urandom_range(31)))),
                        7'($urandom_range(127)),
                        10'(pick_value(31'd1, 31'd1023, 31'($urandom_range(2, 40)))),
                        8'(pick_value(31'd0, 31'd255, 31'($urandom_range(1, 6)))),
                        8'(pick_value(31'd0, 31'd255, 31'($urandom_range(1, 8)))),
                        20'(pick_value(31'd0, 31'hFFFFF, 31'($urandom_range(60000)))),
                        pick_value(31'd0, 31'h7FFFFFFF, 31'($urandom_range(150000))));
        end
    endtask

    // one well-formed homing run: shift, first end, standstill, release, other end
    task automatic homing_attempt();
        int          first_len;
        logic [31:0] end_pos;
        first_len = (shadow_min_run > 8'd12) ? 16 : shadow_min_run + 3;
        case ($urandom_range(5))
            0:       end_pos = $urandom();
            1:       end_pos = 32'h8000_0000;
            2:       end_pos = 32'h7FFF_FFFF;
            3:       end_pos = {1'b0, shadow_min_course} - 32'd1 + $urandom_range(2);
            4:       end_pos = -({1'b0, shadow_min_course} - 32'd1 + $urandom_range(2));
            default: end_pos = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
        send_req(OP_START, coin(), coin(), $urandom());
        repeat ($urandom_range(3)) tick(1'b0, coin(), $urandom());
        tick(1'b1, coin(), $urandom());
        repeat ($urandom_range(first_len)) tick(coin(), 1'b0, $urandom());
        tick(coin(), 1'b1, $urandom());
        repeat ($urandom_range(3)) tick(1'b0, coin(), $urandom());
        tick(1'b1, coin(), $urandom());
        repeat ($urandom_range(3)) tick(coin(), 1'b1, $urandom());
        tick(coin(), 1'b0, $urandom());
        repeat ($urandom_range(4)) tick(coin(), 1'b0, $urandom());
        tick(coin(), 1'b1, end_pos);
        repeat ($urandom_range(2)) tick(coin(), coin(), $urandom());
    endtask

    initial begin
        int ph;
        int phase_end;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_RUN_CURRENT;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_START;
        req_ch.standstill <= 1'b0;
        req_ch.stall_flag <= 1'b0;
        req_ch.position   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // shift timeout, search timeouts near the top current, restart
        load_config(5'd29, 7'h3F, 10'd2, 8'd255, 8'd2, 20'hFFFFF, 31'd0);
        send_req(OP_POLL, 1'b1, 1'b1, 32'h7FFF_FFFF);
        send_req(OP_START, 1'b0, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_req(OP_POLL, 1'b0, 1'b0, 32'h8000_0000);
        send_req(OP_POLL, 1'b1, 1'b1, 32'h0);
        send_req(OP_START, 1'b1, 1'b1, 32'h5555_5555);
        send_req(OP_POLL, 1'b1, 1'b0, 32'hAAAA_AAAA);
        send_req(OP_POLL, 1'b0, 1'b1, 32'h1);
        send_req(OP_POLL, 1'b0, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b0, 32'h0);
        send_req(OP_START, 1'b0, 1'b0, 32'h0);
        drain();

        // release with no ticks left, then a full run ending at the most negative position
        load_config(5'd0, 7'h40, 10'd1023, 8'd0, 8'd0, 20'd0, 31'h7FFFFFFF);
        send_req(OP_START, 1'b0, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b1, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b1, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b1, 32'h0);
        send_req(OP_START, 1'b0, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b0, 1'b1, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b0, 32'h0);
        send_req(OP_POLL, 1'b1, 1'b1, 32'h8000_0000);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 75; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 75; end
                default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
            endcase
            random_config(ph);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(3, 10))
                        send_req(($urandom_range(3) == 0) ? OP_START : OP_POLL,
                                 coin(), coin(), $urandom());
                end else begin
                    homing_attempt();
                end
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
